// ----- src/segment_box_slab_intersect_top_assert.svh -----
// ---------------------------------------------------------------------------
// Slab intersection assertion macros
// Assertion macros shared by the slab intersection RTL. Clock and reset are
// taken from the including module's clk and rst_n ports.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_BOX_SLAB_INTERSECT_TOP_ASSERT_SVH
`define SEGMENT_BOX_SLAB_INTERSECT_TOP_ASSERT_SVH

// Same-cycle implication under reset.
`define SBS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define SBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sbs_pkg.sv -----
// ---------------------------------------------------------------------------
// Slab intersection package
// Types, constants and helper functions for the segment versus box test.
// ---------------------------------------------------------------------------
package sbs_pkg;

    localparam int COORD_W       = 32;
    localparam int FRAC_W        = 16;
    localparam int T_W           = FRAC_W + 1;
    localparam int DIV_STEPS     = FRAC_W + 1;
    localparam int STEPS_PER_STG = 2;
    localparam int DIV_STG       = (DIV_STEPS + STEPS_PER_STG - 1) / STEPS_PER_STG;
    localparam int NUM_W         = COORD_W + 1;
    localparam int REM_W         = COORD_W + 2;
    localparam int TS_W          = T_W + 1;
    localparam int THR_W         = 16;
    localparam int NUM_AXES      = 3;
    localparam int NUM_LANES     = 2 * NUM_AXES;

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_W;

    localparam logic [1:0] KIND_NORM = 2'd0;
    localparam logic [1:0] KIND_ZERO = 2'd1;
    localparam logic [1:0] KIND_NEG  = 2'd2;
    localparam logic [1:0] KIND_SAT  = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] delta_x;
        logic signed [COORD_W-1:0] delta_y;
        logic signed [COORD_W-1:0] delta_z;
        logic signed [COORD_W-1:0] box_lo_x;
        logic signed [COORD_W-1:0] box_lo_y;
        logic signed [COORD_W-1:0] box_lo_z;
        logic signed [COORD_W-1:0] box_hi_x;
        logic signed [COORD_W-1:0] box_hi_y;
        logic signed [COORD_W-1:0] box_hi_z;
    } query_t;

    typedef struct packed {
        logic           hit;
        logic [T_W-1:0] entry_param;
    } result_t;

    // One division lane: restoring divider state plus the special-case kind.
    typedef struct packed {
        logic [1:0]         kind;
        logic [REM_W-1:0]   rem;
        logic [COORD_W-1:0] den;
        logic [T_W-1:0]     quo;
    } lane_t;

    typedef struct packed {
        logic [NUM_AXES-1:0]        par;
        logic [NUM_AXES-1:0]        par_ok;
        lane_t [NUM_LANES-1:0]      lane;
    } stage_t;

    // One restoring division step: compare, subtract, shift in the quotient bit.
    function automatic lane_t div_step(lane_t l);
        lane_t            r;
        logic             ge;
        logic [REM_W-1:0] diff;
        r    = l;
        ge   = (l.rem >= {2'b00, l.den});
        diff = ge ? (l.rem - {2'b00, l.den}) : l.rem;
        r.rem = {diff[REM_W-2:0], 1'b0};
        r.quo = {l.quo[T_W-2:0], ge};
        return r;
    endfunction

    // Plane parameter of a finished lane, saturated to [-1, T_ONE + 1].
    function automatic logic signed [TS_W-1:0] lane_t_value(lane_t l);
        logic signed [TS_W-1:0] v;
        case (l.kind)
            KIND_ZERO: v = '0;
            KIND_NEG:  v = '1;
            KIND_SAT:  v = $signed({1'b0, T_ONE}) + TS_W'(1);
            default:
            begin
                if (l.quo > T_ONE)
                    v = $signed({1'b0, T_ONE}) + TS_W'(1);
                else
                    v = $signed({1'b0, l.quo});
            end
        endcase
        return v;
    endfunction

endpackage

// ----- src/segment_box_slab_intersect_top.sv -----
// ---------------------------------------------------------------------------
// Segment versus axis-aligned box slab test
// Pipelined slab intersection returning hit and entry parameter per query.
// ---------------------------------------------------------------------------
// Usage: a query (segment origin, direction and box corners, all signed
// Q16.16) is transferred at a rising edge where start is high and busy is
// low. busy is held low: the pipeline takes one query in every cycle and
// never backs up, because the receiver cannot hold results off.
// Each query yields one result on the result port, marked by done for
// exactly one cycle, after the preparation, divider and output registers;
// results leave in the order queries entered. The six restoring dividers
// resolve up to two quotient bits per stage over nine stages, and are led by
// one preparation stage and followed by one output stage that merges the axes.
// Throughput is one query per cycle.
// The parallel threshold register resets to 1. It is written through cfg_we and
// cfg_data only while the pipeline is empty; the user, not the block, ensures this.
// Reset clears all valid bits, so no stray done follows reset; payload
// registers are not reset.
// ---------------------------------------------------------------------------
module segment_box_slab_intersect_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  sbs_pkg::query_t       query,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_data,
    output logic                  done,
    output sbs_pkg::result_t      result
);

    `include "segment_box_slab_intersect_top_assert.svh"

    // Pipeline depth: preparation stage plus divider stages.
    localparam int NSTG = sbs_pkg::DIV_STG + 1;

    logic [sbs_pkg::THR_W-1:0] thr_reg;
    logic [NSTG-1:0]           valid_reg;
    sbs_pkg::stage_t           pipe_reg  [NSTG];
    sbs_pkg::stage_t           pipe_next [NSTG];
    logic                      done_reg;
    sbs_pkg::result_t          result_reg;
    sbs_pkg::result_t          result_next;

    logic signed [sbs_pkg::COORD_W-1:0] ax_o  [sbs_pkg::NUM_AXES];
    logic signed [sbs_pkg::COORD_W-1:0] ax_d  [sbs_pkg::NUM_AXES];
    logic signed [sbs_pkg::COORD_W-1:0] ax_lo [sbs_pkg::NUM_AXES];
    logic signed [sbs_pkg::COORD_W-1:0] ax_hi [sbs_pkg::NUM_AXES];

    assign busy = 1'b0;

    assign ax_o[0]  = query.origin_x;
    assign ax_o[1]  = query.origin_y;
    assign ax_o[2]  = query.origin_z;
    assign ax_d[0]  = query.delta_x;
    assign ax_d[1]  = query.delta_y;
    assign ax_d[2]  = query.delta_z;
    assign ax_lo[0] = query.box_lo_x;
    assign ax_lo[1] = query.box_lo_y;
    assign ax_lo[2] = query.box_lo_z;
    assign ax_hi[0] = query.box_hi_x;
    assign ax_hi[1] = query.box_hi_y;
    assign ax_hi[2] = query.box_hi_z;

    // Preparation: the parallel test per axis and the divider set-up per plane.
    // A quotient is split into sign and magnitude; a numerator of at least
    // twice the divisor saturates at once, so the divider only sees a < 2b.
    // The divider stages follow in the same block: each applies up to two
    // restoring steps to all six lanes.
    always_comb
    begin
        logic [sbs_pkg::COORD_W-1:0]      dmag;
        logic signed [sbs_pkg::NUM_W-1:0] num;
        logic [sbs_pkg::NUM_W-1:0]        nmag;
        logic signed [sbs_pkg::COORD_W-1:0] plane;
        pipe_next[0] = '0;
        for (int a = 0; a < sbs_pkg::NUM_AXES; a++)
        begin
            dmag = ax_d[a][sbs_pkg::COORD_W-1] ? (~ax_d[a] + 1'b1) : ax_d[a];
            pipe_next[0].par[a] = (ax_d[a] == '0) ||
                (dmag < {{(sbs_pkg::COORD_W - sbs_pkg::THR_W){1'b0}}, thr_reg});
            pipe_next[0].par_ok[a] = (ax_o[a] >= ax_lo[a]) && (ax_o[a] <= ax_hi[a]);
            for (int p = 0; p < 2; p++)
            begin
                plane = (p == 0) ? ax_lo[a] : ax_hi[a];
                num   = {plane[sbs_pkg::COORD_W-1], plane} -
                        {ax_o[a][sbs_pkg::COORD_W-1], ax_o[a]};
                nmag  = num[sbs_pkg::NUM_W-1] ? (~num + 1'b1) : num;
                pipe_next[0].lane[2*a+p].den = dmag;
                pipe_next[0].lane[2*a+p].quo = '0;
                pipe_next[0].lane[2*a+p].rem = {1'b0, nmag};
                if (num == '0)
                    pipe_next[0].lane[2*a+p].kind = sbs_pkg::KIND_ZERO;
                else if (num[sbs_pkg::NUM_W-1] != ax_d[a][sbs_pkg::COORD_W-1])
                    pipe_next[0].lane[2*a+p].kind = sbs_pkg::KIND_NEG;
                else if ({1'b0, nmag} >= {1'b0, dmag, 1'b0})
                    pipe_next[0].lane[2*a+p].kind = sbs_pkg::KIND_SAT;
                else
                    pipe_next[0].lane[2*a+p].kind = sbs_pkg::KIND_NORM;
            end
        end
        for (int k = 1; k < NSTG; k++)
        begin
            pipe_next[k] = pipe_reg[k-1];
            for (int s = 0; s < sbs_pkg::STEPS_PER_STG; s++)
            begin
                if ((k - 1) * sbs_pkg::STEPS_PER_STG + s < sbs_pkg::DIV_STEPS)
                begin
                    for (int l = 0; l < sbs_pkg::NUM_LANES; l++)
                        pipe_next[k].lane[l] = sbs_pkg::div_step(pipe_next[k].lane[l]);
                end
            end
        end
    end

    // Merge: order each plane pair and narrow the interval, which starts at [0, 1].
    always_comb
    begin
        logic signed [sbs_pkg::TS_W-1:0] tmin;
        logic signed [sbs_pkg::TS_W-1:0] tmax;
        logic signed [sbs_pkg::TS_W-1:0] t1;
        logic signed [sbs_pkg::TS_W-1:0] t2;
        logic signed [sbs_pkg::TS_W-1:0] tlo;
        logic signed [sbs_pkg::TS_W-1:0] thi;
        logic                            hit;
        tmin = '0;
        tmax = $signed({1'b0, sbs_pkg::T_ONE});
        hit  = 1'b1;
        for (int a = 0; a < sbs_pkg::NUM_AXES; a++)
        begin
            t1  = sbs_pkg::lane_t_value(pipe_reg[NSTG-1].lane[2*a]);
            t2  = sbs_pkg::lane_t_value(pipe_reg[NSTG-1].lane[2*a+1]);
            tlo = (t1 > t2) ? t2 : t1;
            thi = (t1 > t2) ? t1 : t2;
            if (pipe_reg[NSTG-1].par[a])
            begin
                if (!pipe_reg[NSTG-1].par_ok[a])
                    hit = 1'b0;
            end
            else
            begin
                if (tlo > tmin)
                    tmin = tlo;
                if (thi < tmax)
                    tmax = thi;
            end
        end
        if (tmin > tmax)
            hit = 1'b0;
        result_next.hit         = hit;
        result_next.entry_param = hit ? tmin[sbs_pkg::T_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= sbs_pkg::THR_W'(1);
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_data;
            valid_reg <= {valid_reg[NSTG-2:0], start & ~busy};
            done_reg  <= valid_reg[NSTG-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTG; k++)
            pipe_reg[k] <= pipe_next[k];
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `SBS_ASSERT_IMP(a_never_busy, 1'b1, !busy, "pipeline must never report busy")
    `SBS_ASSERT_NEXT(a_last_stage_done, valid_reg[NSTG-1], done,
        "a valid last stage must produce a result")
    `SBS_ASSERT_IMP(a_miss_zero, done && !result.hit, result.entry_param == '0,
        "a miss must report a zero entry parameter")
    `SBS_ASSERT_IMP(a_hit_range, done && result.hit, result.entry_param <= sbs_pkg::T_ONE,
        "entry parameter of a hit exceeds one")

endmodule
